### design/lapst_pkg.sv
// ----------------------------------------------------------------------------
// lapst_pkg: shared types and constants for the five-point Laplacian stencil
// Result field widths, configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package lapst_pkg;

    localparam int VALUE_W    = 48;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GRID_W_W   = 11;
    localparam int OUT_DATA_W = 80;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last_of_item;
        logic               end_of_frame;
    } result_t;

endpackage

### design/laplacian_five_point_stencil.sv
// ----------------------------------------------------------------------------
// laplacian_five_point_stencil: streaming 2-D five-point Laplacian
// Takes grid samples in raster order and emits the stencil (or edge pass-through)
// for the point one row above each sample; last-row samples are also passed through.
// ----------------------------------------------------------------------------
// A result enters the result queue when the sample that completes it is accepted.
// Throughput: one sample per cycle while the result queue has room for two results;
// last-row samples give two results each, which the single result port gives out in turn.
// Line stores hold both earlier rows in one two-read-port memory.
// Reset clears counters, result queue and configuration (8 x 8, width at most MAX_WIDTH);
// line store contents stay undefined until written.

module laplacian_five_point_stencil #(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [lapst_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lapst_pkg::CFG_DATA_W-1:0]       cfg_wdata,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,   // sample

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [lapst_pkg::OUT_DATA_W-1:0]       m_tdata,   // value, col, row
    output logic                                   m_tuser,   // last_of_item
    output logic                                   m_tlast    // end_of_frame
);

    localparam int ADDR_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int DW      = SAMPLE_BITS + 2;
    localparam int SX_W    = 22;
    localparam int SY_W    = 32;
    localparam int PX_W    = DW + SX_W + 1;
    localparam int PY_W    = DW + SY_W + 1;
    localparam int SUM_W   = SAMPLE_BITS + 41;
    localparam int VW      = lapst_pkg::VALUE_W;
    localparam int RST_WM1 = (8 > MAX_WIDTH) ? MAX_WIDTH - 1 : 7;
    localparam int RST_SX  = RST_WM1 * RST_WM1;
    localparam int QD      = 4;
    localparam int QP_W    = 2;
    localparam int QC_W    = 3;

    // configuration, held as last column / last row and the two scale factors
    logic [ADDR_W-1:0]               wlast_reg;
    logic [lapst_pkg::ROW_W-1:0]     hlast_reg;
    logic [SX_W-1:0]                 sx_reg;
    logic [SY_W-1:0]                 sy_reg;

    logic [lapst_pkg::GRID_W_W-1:0]  cfg_wm1;
    logic [lapst_pkg::ROW_W-1:0]     cfg_hm1;
    logic                            cfg_hit;

    always_comb
    begin
        if (cfg_wdata[lapst_pkg::GRID_W_W-1:0] < lapst_pkg::GRID_W_W'(3))
            cfg_wm1 = lapst_pkg::GRID_W_W'(2);
        else if (32'(cfg_wdata[lapst_pkg::GRID_W_W-1:0]) > 32'(MAX_WIDTH))
            cfg_wm1 = lapst_pkg::GRID_W_W'(MAX_WIDTH - 1);
        else
            cfg_wm1 = cfg_wdata[lapst_pkg::GRID_W_W-1:0] - lapst_pkg::GRID_W_W'(1);

        if (cfg_wdata < lapst_pkg::CFG_DATA_W'(3))
            cfg_hm1 = lapst_pkg::ROW_W'(2);
        else
            cfg_hm1 = cfg_wdata - lapst_pkg::ROW_W'(1);

        cfg_hit = cfg_we && ((cfg_index == lapst_pkg::REG_GRID_WIDTH) ||
                             (cfg_index == lapst_pkg::REG_GRID_HEIGHT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg <= ADDR_W'(RST_WM1);
            hlast_reg <= lapst_pkg::ROW_W'(7);
            sx_reg    <= SX_W'(RST_SX);
            sy_reg    <= SY_W'(49);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lapst_pkg::REG_GRID_WIDTH:
                begin
                    wlast_reg <= ADDR_W'(cfg_wm1);
                    sx_reg    <= SX_W'(cfg_wm1) * SX_W'(cfg_wm1);
                end
                lapst_pkg::REG_GRID_HEIGHT:
                begin
                    hlast_reg <= cfg_hm1;
                    sy_reg    <= SY_W'(cfg_hm1) * SY_W'(cfg_hm1);
                end
                default:
                begin
                    wlast_reg <= wlast_reg;
                end
            endcase
        end
    end

    // raster position of the next sample
    logic [ADDR_W-1:0]            col_reg, col_next;
    logic [lapst_pkg::ROW_W-1:0]  row_reg, row_next;
    logic                         accept;

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == wlast_reg)
            begin
                col_next = '0;
                row_next = (row_reg == hlast_reg) ? '0 : row_reg + lapst_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line store: high half is the row two above, low half the row above
    logic [2*SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
    logic [2*SAMPLE_BITS-1:0] rd_a_reg;
    logic [2*SAMPLE_BITS-1:0] rd_b_reg;
    logic [SAMPLE_BITS-1:0]   left_reg;
    logic signed [SAMPLE_BITS-1:0] s_in;
    logic signed [SAMPLE_BITS-1:0] u;

    assign s_in = s_tdata[SAMPLE_BITS-1:0];
    assign u    = rd_a_reg[SAMPLE_BITS-1:0];

    // prefetch the current and next column for the position the counter will hold
    always_ff @(posedge clk)
    begin
        if (accept)
            line_mem[col_reg] <= {u, s_in};
        rd_a_reg <= line_mem[col_next];
        rd_b_reg <= line_mem[col_next + ADDR_W'(1)];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            left_reg <= u;
    end

    // stencil arithmetic
    logic signed [SAMPLE_BITS-1:0] up;
    logic signed [SAMPLE_BITS-1:0] right;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [DW-1:0]          dx, dy;
    logic signed [PX_W-1:0]        px;
    logic signed [PY_W-1:0]        py;
    logic signed [SUM_W-1:0]       sum;
    logic                          pos_ovf, neg_ovf;
    logic [VW-1:0]                 stencil_val;
    logic                          edge_pt;
    logic                          last_row;
    logic                          has_a;
    lapst_pkg::result_t            res_a, res_b;
    logic [15:0]                   col_wide;

    always_comb
    begin
        up    = rd_a_reg[2*SAMPLE_BITS-1:SAMPLE_BITS];
        right = rd_b_reg[SAMPLE_BITS-1:0];
        left  = left_reg;

        dx  = DW'(left) + DW'(right) - DW'(u) - DW'(u);
        dy  = DW'(up) + DW'(s_in) - DW'(u) - DW'(u);
        px  = dx * $signed({1'b0, sx_reg});
        py  = dy * $signed({1'b0, sy_reg});
        sum = SUM_W'(px) + SUM_W'(py);

        // saturate to the signed result range
        pos_ovf = !sum[SUM_W-1] && (|sum[SUM_W-2:VW-1]);
        neg_ovf = sum[SUM_W-1] && !(&sum[SUM_W-2:VW-1]);
        if (pos_ovf)
            stencil_val = {1'b0, {(VW-1){1'b1}}};
        else if (neg_ovf)
            stencil_val = {1'b1, {(VW-1){1'b0}}};
        else
            stencil_val = sum[VW-1:0];

        edge_pt  = (row_reg == lapst_pkg::ROW_W'(1)) || (col_reg == '0) ||
                   (col_reg == wlast_reg);
        last_row = (row_reg == hlast_reg);
        has_a    = (row_reg != '0);
        col_wide = 16'(col_reg);

        res_a.value        = edge_pt ? VW'(u) : stencil_val;
        res_a.col          = col_wide[lapst_pkg::COL_W-1:0];
        res_a.row          = row_reg - lapst_pkg::ROW_W'(1);
        res_a.last_of_item = !last_row;
        res_a.end_of_frame = 1'b0;

        res_b.value        = VW'(s_in);
        res_b.col          = col_wide[lapst_pkg::COL_W-1:0];
        res_b.row          = row_reg;
        res_b.last_of_item = 1'b1;
        res_b.end_of_frame = (col_reg == wlast_reg);
    end

    // result queue: takes up to two results a cycle, gives one
    lapst_pkg::result_t q_mem [QD];
    logic [QP_W-1:0]    q_wr_reg, q_rd_reg;
    logic [QC_W-1:0]    q_cnt_reg, q_cnt_next;
    logic [QC_W-1:0]    n_push;
    logic               pop;
    lapst_pkg::result_t q_head;

    assign s_tready = (q_cnt_reg <= QC_W'(QD - 2));
    assign pop      = m_tvalid && m_tready;

    always_comb
    begin
        n_push = '0;
        if (accept && has_a)
            n_push = last_row ? QC_W'(2) : QC_W'(1);
        q_cnt_next = q_cnt_reg + n_push - QC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            q_wr_reg  <= q_wr_reg + QP_W'(n_push);
            q_rd_reg  <= q_rd_reg + QP_W'(pop);
            q_cnt_reg <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_a)
        begin
            q_mem[q_wr_reg] <= res_a;
            if (last_row)
                q_mem[q_wr_reg + QP_W'(1)] <= res_b;
        end
    end

    assign q_head   = q_mem[q_rd_reg];
    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = {6'b0, q_head.row, q_head.col, q_head.value};
    assign m_tuser  = q_head.last_of_item;
    assign m_tlast  = q_head.end_of_frame;

endmodule
